@@ hdl/ccd_pkg.sv @@
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants of the coin change dispenser
// Field widths, status codes, sequencer states and the command word that
// travels from the front classifier to the back sequencer.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int unsigned COUNT_W       = 10;
  localparam int unsigned AMT_W         = 15;
  localparam int unsigned COUNT_MAX_DEF = 1023;

  // x / 10 == (x * RECIP) >> 19 and x / 5 == (x * RECIP) >> 18, exact for x < 2**15
  localparam logic [15:0] RECIP      = 16'hCCCD;
  localparam int unsigned SHIFT_TEN  = 19;
  localparam int unsigned SHIFT_FIVE = 18;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_AMOUNT = 2'd1,
    ST_MIN_OVER   = 2'd2,
    ST_MIN_STOCK  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEN,
    S_FIVE,
    S_LOW,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               is_load;
    logic [AMT_W-1:0]   amount;
    logic               zero_amount;
    logic               req_over;
    logic [AMT_W-1:0]   rem;
    logic [COUNT_W-1:0] min_tens;
    logic [COUNT_W-1:0] min_fives;
    logic [COUNT_W-1:0] min_twos;
    logic [COUNT_W-1:0] min_ones;
    logic [COUNT_W-1:0] load_tens;
    logic [COUNT_W-1:0] load_fives;
    logic [COUNT_W-1:0] load_twos;
    logic [COUNT_W-1:0] load_ones;
    logic [AMT_W-1:0]   load_value;
  } cmd_t;

endpackage

@@ hdl/ccd_front.sv @@
// ----------------------------------------------------------------------------
// ccd_front: request classifier
// Turns an incoming word into a command: saturated load counts and their
// value, the weighted sum of the minimums and the checks that need no stock.
// ----------------------------------------------------------------------------
module ccd_front #(
  parameter int unsigned COUNT_MAX = ccd_pkg::COUNT_MAX_DEF
) (
  input  logic                         req_type,
  input  logic [ccd_pkg::AMT_W-1:0]    amount,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_tens,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_fives,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_twos,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_ones,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_tens,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_fives,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_twos,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_ones,
  output ccd_pkg::cmd_t                cmd
);
  import ccd_pkg::*;

  // saturation level clipped to the field width
  localparam logic [COUNT_W-1:0] SAT_VAL =
    (COUNT_MAX >= (1 << COUNT_W) - 1) ? {COUNT_W{1'b1}} : COUNT_W'(COUNT_MAX);

  function automatic logic [COUNT_W-1:0] sat(input logic [COUNT_W-1:0] x);
    return (x > SAT_VAL) ? SAT_VAL : x;
  endfunction

  function automatic logic [AMT_W-1:0] coin_value(
    input logic [COUNT_W-1:0] t, input logic [COUNT_W-1:0] f,
    input logic [COUNT_W-1:0] w, input logic [COUNT_W-1:0] o);
    return AMT_W'(t) * AMT_W'(10) + AMT_W'(f) * AMT_W'(5) +
           AMT_W'(w) * AMT_W'(2) + AMT_W'(o);
  endfunction

  logic [AMT_W-1:0] req_sum;

  always_comb begin
    req_sum = coin_value(min_tens, min_fives, min_twos, min_ones);

    cmd.is_load     = req_type;
    cmd.amount      = amount;
    cmd.zero_amount = (amount == '0);
    cmd.req_over    = (req_sum > amount);
    cmd.rem         = amount - req_sum;
    cmd.min_tens    = min_tens;
    cmd.min_fives   = min_fives;
    cmd.min_twos    = min_twos;
    cmd.min_ones    = min_ones;
    cmd.load_tens   = sat(load_tens);
    cmd.load_fives  = sat(load_fives);
    cmd.load_twos   = sat(load_twos);
    cmd.load_ones   = sat(load_ones);
    cmd.load_value  = coin_value(cmd.load_tens, cmd.load_fives,
                                 cmd.load_twos, cmd.load_ones);
  end

endmodule

@@ hdl/ccd_queue.sv @@
// ----------------------------------------------------------------------------
// ccd_queue: two-entry command queue
// Decouples the classifier from the sequencer so that each side stalls alone.
// ----------------------------------------------------------------------------
module ccd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ccd_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output ccd_pkg::cmd_t rd_data
);
  import ccd_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/ccd_back.sv @@
// ----------------------------------------------------------------------------
// ccd_back: dispense sequencer
// Holds the stock, checks each command against it, pays the remainder in
// tens, fives, then twos with ones; writes the result to the output register.
// ----------------------------------------------------------------------------
module ccd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ccd_pkg::cmd_t                q_data,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   status,
  output logic [ccd_pkg::COUNT_W-1:0]  out_tens,
  output logic [ccd_pkg::COUNT_W-1:0]  out_fives,
  output logic [ccd_pkg::COUNT_W-1:0]  out_twos,
  output logic [ccd_pkg::COUNT_W-1:0]  out_ones,
  output logic [ccd_pkg::AMT_W-1:0]    shortfall,
  output logic [ccd_pkg::AMT_W-1:0]    stock_value
);
  import ccd_pkg::*;

  state_t state, state_next;

  cmd_t               cmd;
  status_t            res_status;
  logic [AMT_W-1:0]   rem;
  logic [COUNT_W-1:0] cnt_tens, cnt_fives, cnt_twos, cnt_ones;

  logic [COUNT_W-1:0] stock_tens, stock_fives, stock_twos, stock_ones;
  logic [AMT_W-1:0]   value;
  logic               out_valid;

  logic    out_free;
  logic    take_cmd;
  logic    emit;
  status_t chk_status;

  logic [COUNT_W-1:0] avail_tens, avail_fives, avail_twos, avail_ones;
  logic [30:0]        prod;
  logic [11:0]        q_ten;
  logic [12:0]        q_five;
  logic [13:0]        q_two;
  logic [COUNT_W-1:0] take_ten, take_five, take_two, take_one;
  logic [AMT_W-1:0]   rem_ten, rem_five, rem_two, rem_one;
  logic [AMT_W-1:0]   value_next;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (cmd.is_load || chk_status != ST_OK) state_next = S_EMIT;
        else                                    state_next = S_TEN;
      end
      S_TEN:   state_next = S_FIVE;
      S_FIVE:  state_next = S_LOW;
      S_LOW:   state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = q_valid ? S_CHECK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take_cmd = 1'b0;
    emit     = 1'b0;
    unique case (state)
      S_IDLE: take_cmd = q_valid;
      S_EMIT: begin
        emit     = out_free;
        take_cmd = out_free && q_valid;
      end
      default: begin
        take_cmd = 1'b0;
        emit     = 1'b0;
      end
    endcase
  end

  assign q_pop = take_cmd;

  // stock checks, first failing one wins
  always_comb begin
    if (cmd.zero_amount || cmd.amount > value)  chk_status = ST_BAD_AMOUNT;
    else if (cmd.req_over)                       chk_status = ST_MIN_OVER;
    else if (cmd.min_tens > stock_tens || cmd.min_fives > stock_fives ||
             cmd.min_twos > stock_twos || cmd.min_ones > stock_ones)
                                                 chk_status = ST_MIN_STOCK;
    else                                         chk_status = ST_OK;
  end

  // greedy payment datapath, one state each for tens, fives and twos with ones
  always_comb begin
    avail_tens  = stock_tens  - cmd.min_tens;
    avail_fives = stock_fives - cmd.min_fives;
    avail_twos  = stock_twos  - cmd.min_twos;
    avail_ones  = stock_ones  - cmd.min_ones;

    prod   = 31'(rem) * 31'(RECIP);
    q_ten  = prod[30:SHIFT_TEN];
    q_five = prod[30:SHIFT_FIVE];

    take_ten  = (12'(avail_tens) < q_ten) ? avail_tens : q_ten[COUNT_W-1:0];
    rem_ten   = rem - AMT_W'(take_ten) * AMT_W'(10);
    take_five = (13'(avail_fives) < q_five) ? avail_fives : q_five[COUNT_W-1:0];
    rem_five  = rem - AMT_W'(take_five) * AMT_W'(5);

    q_two    = rem[AMT_W-1:1];
    take_two = (14'(avail_twos) < q_two) ? avail_twos : q_two[COUNT_W-1:0];
    rem_two  = rem - {4'b0, take_two, 1'b0};
    take_one = (AMT_W'(avail_ones) < rem_two) ? avail_ones : rem_two[COUNT_W-1:0];
    rem_one  = rem_two - AMT_W'(take_one);

    if (cmd.is_load)            value_next = cmd.load_value;
    else if (res_status == ST_OK) value_next = value - (cmd.amount - rem);
    else                        value_next = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (take_cmd) begin
      cmd <= q_data;
    end
    unique case (state)
      S_CHECK: begin
        res_status <= cmd.is_load ? ST_OK : chk_status;
        rem        <= (cmd.is_load || chk_status != ST_OK) ? '0 : cmd.rem;
        cnt_tens   <= '0;
        cnt_fives  <= '0;
        cnt_twos   <= '0;
        cnt_ones   <= '0;
      end
      S_TEN: begin
        cnt_tens <= cmd.min_tens + take_ten;
        rem      <= rem_ten;
      end
      S_FIVE: begin
        cnt_fives <= cmd.min_fives + take_five;
        rem       <= rem_five;
      end
      S_LOW: begin
        cnt_twos <= cmd.min_twos + take_two;
        cnt_ones <= cmd.min_ones + take_one;
        rem      <= rem_one;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  // stock and value, changed only when a result is written out
  always_ff @(posedge clk) begin
    if (rst) begin
      stock_tens  <= '0;
      stock_fives <= '0;
      stock_twos  <= '0;
      stock_ones  <= '0;
      value       <= '0;
    end else if (emit) begin
      value <= value_next;
      if (cmd.is_load) begin
        stock_tens  <= cmd.load_tens;
        stock_fives <= cmd.load_fives;
        stock_twos  <= cmd.load_twos;
        stock_ones  <= cmd.load_ones;
      end else if (res_status == ST_OK) begin
        stock_tens  <= stock_tens  - cnt_tens;
        stock_fives <= stock_fives - cnt_fives;
        stock_twos  <= stock_twos  - cnt_twos;
        stock_ones  <= stock_ones  - cnt_ones;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= res_status;
      out_tens    <= cnt_tens;
      out_fives   <= cnt_fives;
      out_twos    <= cnt_twos;
      out_ones    <= cnt_ones;
      shortfall   <= rem;
      stock_value <= value_next;
    end
  end

endmodule

@@ hdl/coin_change_dispenser.sv @@
// ----------------------------------------------------------------------------
// coin_change_dispenser: coin dispenser with limited stock
// Keeps counts of 10, 5, 2 and 1 rupee coins, loads them and pays amounts.
// ----------------------------------------------------------------------------
// Usage: push a word when full is low; read the oldest result while empty is
// low and pop it. A load word (req_type 1) replaces the four stock counts,
// each clipped to COUNT_MAX. A dispense word (req_type 0) is rejected with
// status 1 if the amount is zero or above the stock value, 2 if the
// minimums are worth more than the amount, 3 if a minimum exceeds its own
// coin's stock; a rejected word leaves the stock alone and returns zero
// coins. Otherwise the minimums are granted and the rest is paid greedily
// from 10 down to 1; whatever the stock cannot cover comes back as the
// shortfall. Every result carries the stock value after the word. Timing: a
// two-entry command queue takes words at one per cycle until it fills; the
// back sequencer runs check, tens, fives, twos with ones and write-out on a
// dispense, check and write-out on a load or a rejected one, since every
// word depends on the stock left by the one before. The single output
// register lets the next word start while a result still waits to be popped.
// ----------------------------------------------------------------------------
module coin_change_dispenser #(
  parameter int unsigned COUNT_MAX = ccd_pkg::COUNT_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         req_type,
  input  logic [ccd_pkg::AMT_W-1:0]    amount,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_tens,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_fives,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_twos,
  input  logic [ccd_pkg::COUNT_W-1:0]  min_ones,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_tens,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_fives,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_twos,
  input  logic [ccd_pkg::COUNT_W-1:0]  load_ones,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   status,
  output logic [ccd_pkg::COUNT_W-1:0]  out_tens,
  output logic [ccd_pkg::COUNT_W-1:0]  out_fives,
  output logic [ccd_pkg::COUNT_W-1:0]  out_twos,
  output logic [ccd_pkg::COUNT_W-1:0]  out_ones,
  output logic [ccd_pkg::AMT_W-1:0]    shortfall,
  output logic [ccd_pkg::AMT_W-1:0]    stock_value
);
  import ccd_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic accept;

  // accept a word whenever the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // classify the word: saturate loads, weigh minimums
  ccd_front #(
    .COUNT_MAX (COUNT_MAX)
  ) u_front (
    .req_type   (req_type),
    .amount     (amount),
    .min_tens   (min_tens),
    .min_fives  (min_fives),
    .min_twos   (min_twos),
    .min_ones   (min_ones),
    .load_tens  (load_tens),
    .load_fives (load_fives),
    .load_twos  (load_twos),
    .load_ones  (load_ones),
    .cmd        (front_cmd)
  );

  // hold classified commands until the sequencer is free
  ccd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (front_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_cmd)
  );

  // check against stock, pay, update stock, drive the result word
  ccd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (head_cmd),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .out_tens    (out_tens),
    .out_fives   (out_fives),
    .out_twos    (out_twos),
    .out_ones    (out_ones),
    .shortfall   (shortfall),
    .stock_value (stock_value)
  );

endmodule
